### rtl/aduf_pkg.sv
// Shared types and constants for the advertising-data 128-bit UUID filter.
`timescale 1ns / 1ps

package aduf_pkg;

   // UUID length in bytes (2 to 16); the value bytes compared per structure
   localparam int UuidBytes = 16;
   localparam int CmpIdxW   = 5;
   localparam int UuidBits  = 128;
   localparam int CsrDataW  = 64;

   localparam logic [7:0] AdTypeUuid128More = 8'h06;
   localparam logic [7:0] AdTypeUuid128All  = 8'h07;

   // register indexes on the configuration port
   localparam logic CsrUuidLow  = 1'b0;
   localparam logic CsrUuidHigh = 1'b1;

   localparam logic [7:0] MinUuidLen = 8'(UuidBytes + 1);
   localparam logic [CmpIdxW-1:0] CmpLast = CmpIdxW'(UuidBytes);

   typedef enum logic [2:0] {
      PH_LEN   = 3'b001,
      PH_TYPE  = 3'b010,
      PH_VALUE = 3'b100
   } phase_type;

   typedef struct packed {
      logic truncated;
      logic uuid_found;
   } result_type;

endpackage

### rtl/adv_data_uuid128_filter.sv
// Advertising-report walker that flags a matching 128-bit service UUID.
`timescale 1ns / 1ps

// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tdata[7:0] ad_byte, tlast last_byte
// rsp       out  rsp_tvalid/rsp_tready  tdata[0] uuid_found, tdata[1] truncated
// csr       in   csr_wr_en              csr_index selects register, csr_wdata value
//
// One request a cycle while req_tready is high; each byte updates the walk state in the same cycle.
// The result of a report's last byte reaches rsp through the result register, or through the skid while a result waits.
// A two-deep output (result register plus skid) keeps req_tready high while
// one result waits; req_tready drops only when both are full.
// Synchronous active-high reset clears the walk, the output and the UUID.
module adv_data_uuid128_filter (
   input  logic        clock,
   input  logic        reset,
   // request: [7:0] ad_byte
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        req_tvalid,
   output logic        req_tready,
   // response: [0] uuid_found, [1] truncated, [7:2] zero
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [aduf_pkg::CsrDataW-1:0] csr_wdata
);

   // configured UUID, byte 0 in bits 7:0
   logic [aduf_pkg::UuidBits-1:0] uuid_ff;

   // walk state
   aduf_pkg::phase_type            phase_ff, phase_in;
   logic [7:0]                     struct_len_ff, struct_len_in;
   logic [7:0]                     bytes_left_ff, bytes_left_in;
   logic [aduf_pkg::CmpIdxW-1:0]   cmp_idx_ff, cmp_idx_in;
   logic                           cmp_ok_ff, cmp_ok_in;
   logic                           found_ff, found_in;

   // output stage
   logic                     out_valid_ff, skid_valid_ff;
   aduf_pkg::result_type     out_data_ff, skid_data_ff;
   aduf_pkg::result_type     result;

   logic       req_fire;
   logic       push;
   logic       pop;
   logic [7:0] uuid_sel;
   logic [7:0] bl_dec;

   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign push       = req_fire && req_tlast;
   assign pop        = out_valid_ff && rsp_tready;

   // only the low four bits address the UUID
   assign uuid_sel = uuid_ff[{cmp_idx_ff[3:0], 3'b000} +: 8];
   assign bl_dec   = bytes_left_ff - 8'd1;

   always_comb begin
      phase_in      = phase_ff;
      struct_len_in = struct_len_ff;
      bytes_left_in = bytes_left_ff;
      cmp_idx_in    = cmp_idx_ff;
      cmp_ok_in     = cmp_ok_ff;
      found_in      = found_ff;
      unique case (phase_ff)
         aduf_pkg::PH_TYPE: begin
            bytes_left_in = bl_dec;
            cmp_ok_in = (req_tdata == aduf_pkg::AdTypeUuid128More ||
                         req_tdata == aduf_pkg::AdTypeUuid128All) &&
                        (struct_len_ff >= aduf_pkg::MinUuidLen);
            cmp_idx_in = '0;
            phase_in   = (bl_dec == 8'd0) ? aduf_pkg::PH_LEN : aduf_pkg::PH_VALUE;
         end
         aduf_pkg::PH_VALUE: begin
            if (cmp_ok_ff && cmp_idx_ff < aduf_pkg::CmpLast) begin
               cmp_ok_in  = (req_tdata == uuid_sel);
               cmp_idx_in = cmp_idx_ff + 1'b1;
               if (req_tdata == uuid_sel && cmp_idx_in == aduf_pkg::CmpLast) begin
                  found_in = 1'b1;
               end
            end
            bytes_left_in = bl_dec;
            if (bl_dec == 8'd0) begin
               phase_in = aduf_pkg::PH_LEN;
            end
         end
         default: begin
            // length byte; zero length is a structure of its own
            struct_len_in = req_tdata;
            bytes_left_in = req_tdata;
            phase_in = (req_tdata == 8'd0) ? aduf_pkg::PH_LEN : aduf_pkg::PH_TYPE;
         end
      endcase
   end

   assign result.uuid_found = found_in;
   assign result.truncated  = (phase_in != aduf_pkg::PH_LEN);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= aduf_pkg::PH_LEN;
         struct_len_ff <= '0;
         bytes_left_ff <= '0;
         cmp_idx_ff    <= '0;
         cmp_ok_ff     <= 1'b0;
         found_ff      <= 1'b0;
      end else if (req_fire) begin
         if (req_tlast) begin
            // report done: fresh walk for the next byte
            phase_ff      <= aduf_pkg::PH_LEN;
            struct_len_ff <= '0;
            bytes_left_ff <= '0;
            cmp_idx_ff    <= '0;
            cmp_ok_ff     <= 1'b0;
            found_ff      <= 1'b0;
         end else begin
            phase_ff      <= phase_in;
            struct_len_ff <= struct_len_in;
            bytes_left_ff <= bytes_left_in;
            cmp_idx_ff    <= cmp_idx_in;
            cmp_ok_ff     <= cmp_ok_in;
            found_ff      <= found_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uuid_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            aduf_pkg::CsrUuidLow:  uuid_ff[63:0]   <= csr_wdata;
            aduf_pkg::CsrUuidHigh: uuid_ff[127:64] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // result register with skid behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else if (push) begin
            out_data_ff <= result;
         end
      end else if (push) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b000000, out_data_ff.truncated, out_data_ff.uuid_found};

   // skid only fills behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result while the result register is empty");

   // the walk restarts after every report end
   a_walk_cleared: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> (phase_ff == aduf_pkg::PH_LEN && !found_ff &&
                                   bytes_left_ff == 8'd0))
      else $error("walk state not cleared after last byte");

   // value phase always has bytes outstanding
   a_value_bytes_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == aduf_pkg::PH_VALUE) |-> (bytes_left_ff != 8'd0))
      else $error("value phase with no bytes left");

   // compare index never runs past the UUID
   a_cmp_idx_range: assert property (@(posedge clock) disable iff (reset)
      cmp_idx_ff <= aduf_pkg::CmpLast)
      else $error("compare index beyond UUID length");

endmodule
